>>> hdl/tkac_pkg.sv
// ----------------------------------------------------------------------------
// Top-k accuracy counter package
// Field widths, reset constants and the slot bank control bundle.
// ----------------------------------------------------------------------------
package tkac_pkg;

   localparam int SCORE_W = 32;
   localparam int LABEL_W = 10;
   localparam int COUNT_W = 11;
   localparam int TOPK_W  = 3;

   localparam logic signed [SCORE_W-1:0] EMPTY_SCORE = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic [TOPK_W-1:0]         TOPK_RESET  = 3'd5;

   typedef struct packed {
      logic step;
      logic row_end;
   } slot_ctl_type;

endpackage

>>> hdl/tkac_slot_bank.sv
// ----------------------------------------------------------------------------
// Top-k slot bank
// Holds the best scores of the current row with their class numbers, replaces
// the first smallest used slot on a strictly greater score, and checks the
// row label against the used slots.
// ----------------------------------------------------------------------------
module tkac_slot_bank #(
   parameter int MAX_SLOTS = 5,
   parameter int CLASS_W   = 10,
   parameter int KW        = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tkac_pkg::slot_ctl_type                ctl,
   input  logic signed [tkac_pkg::SCORE_W-1:0]   logit,
   input  logic [CLASS_W-1:0]                    class_num,
   input  logic [tkac_pkg::LABEL_W-1:0]          label,
   input  logic [KW-1:0]                         slots_used,
   output logic                                  hit
);
   import tkac_pkg::*;

   localparam int LVL    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 0;
   localparam int LEAVES = 1 << LVL;
   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CMP_W  = (CLASS_W > LABEL_W) ? CLASS_W : LABEL_W;

   typedef struct packed {
      logic               live;
      logic [SCORE_W-1:0] score;
      logic [SLOT_W-1:0]  idx;
   } node_type;

   logic signed [SCORE_W-1:0] best_score_ff [MAX_SLOTS];
   logic [CLASS_W-1:0]        best_class_ff [MAX_SLOTS];
   logic signed [SCORE_W-1:0] best_score_in [MAX_SLOTS];
   logic [CLASS_W-1:0]        best_class_in [MAX_SLOTS];

   node_type node [1:2*LEAVES-1];
   node_type win;
   logic     replace;

   // min tree: ties keep the lower slot
   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         if (i < MAX_SLOTS) begin
            node[LEAVES+i].live  = (i < int'(slots_used));
            node[LEAVES+i].score = best_score_ff[i];
         end else begin
            node[LEAVES+i].live  = 1'b0;
            node[LEAVES+i].score = EMPTY_SCORE;
         end
         node[LEAVES+i].idx = SLOT_W'(i);
      end
      for (int n = LEAVES - 1; n >= 1; n--) begin
         if (node[2*n+1].live &&
             (!node[2*n].live ||
              $signed(node[2*n+1].score) < $signed(node[2*n].score))) begin
            node[n] = node[2*n+1];
         end else begin
            node[n] = node[2*n];
         end
      end
   end

   assign win     = node[1];
   assign replace = logit > $signed(win.score);

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         best_score_in[i] = best_score_ff[i];
         best_class_in[i] = best_class_ff[i];
         if (replace && win.idx == SLOT_W'(i)) begin
            best_score_in[i] = logit;
            best_class_in[i] = class_num;
         end
         if (i < int'(slots_used) && CMP_W'(best_class_in[i]) == CMP_W'(label)) begin
            hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (reset || (ctl.step && ctl.row_end)) begin
            best_score_ff[i] <= EMPTY_SCORE;
            best_class_ff[i] <= '0;
         end else if (ctl.step) begin
            best_score_ff[i] <= best_score_in[i];
            best_class_ff[i] <= best_class_in[i];
         end
      end
   end

endmodule

>>> hdl/topk_accuracy_counter.sv
// ----------------------------------------------------------------------------
// Top-k accuracy counter
// Streaming top-k accuracy over rows of classifier scores (signed Q16.16).
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one class score per request; req_end_of_row marks the last
//   score of a row and samples req_label and req_end_of_batch with it.
//   rsp_* returns one result per row: hit flag, running correct count of the
//   batch (this row included) and the batch-done flag. Other requests give no
//   response.
//   csr_we/csr_wdata write top_k (number of slots checked, 1 to 5) at once;
//   write only while no request is in flight.
//   Throughput is one request per cycle unless a row end stalls (below). A
//   request is held in the input register, and a row end loads the response
//   register when it steps, which raises rsp_valid. The slot update and
//   label check are combinational from the input register.
//   When rsp_ready is low, scores that end no row keep flowing; a row end
//   waits in the input register and req_ready drops until the response
//   register frees up.
//   Reset empties the slots, clears the class and correct counters, restores
//   top_k to 5 and drops both valid flags.
// ----------------------------------------------------------------------------
module topk_accuracy_counter #(
   parameter int MAX_CLASSES = 1024,
   parameter int MAX_SLOTS   = 5,
   parameter int MAX_BATCH   = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tkac_pkg::SCORE_W-1:0]  req_logit,
   input  logic [tkac_pkg::LABEL_W-1:0]         req_label,
   input  logic                                 req_end_of_row,
   input  logic                                 req_end_of_batch,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_row_hit,
   output logic [tkac_pkg::COUNT_W-1:0]         rsp_batch_correct,
   output logic                                 rsp_batch_done,
   input  logic                                 csr_we,
   input  logic [tkac_pkg::TOPK_W-1:0]          csr_wdata
);
   import tkac_pkg::*;

   localparam int CLASS_W = $clog2(MAX_CLASSES);
   localparam int CORR_W  = $clog2(MAX_BATCH + 1);
   localparam int KW      = $clog2(MAX_SLOTS + 1);

   logic                      in_valid_ff;
   logic signed [SCORE_W-1:0] in_logit_ff;
   logic [LABEL_W-1:0]        in_label_ff;
   logic                      in_eor_ff;
   logic                      in_eob_ff;

   logic [TOPK_W-1:0]  top_k_ff;
   logic [KW-1:0]      slots_used;
   logic [CLASS_W-1:0] class_ff;
   logic [CLASS_W-1:0] class_in;
   logic [CORR_W-1:0]  correct_ff;
   logic [CORR_W-1:0]  correct_in;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [COUNT_W-1:0] rsp_correct_ff;
   logic               rsp_done_ff;

   logic         step;
   logic         hit;
   slot_ctl_type slot_ctl;

   assign step      = in_valid_ff && (!in_eor_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      if (top_k_ff == '0) begin
         slots_used = KW'(1);
      end else if (int'(top_k_ff) > MAX_SLOTS) begin
         slots_used = KW'(MAX_SLOTS);
      end else begin
         slots_used = KW'(top_k_ff);
      end
   end

   assign slot_ctl.step    = step;
   assign slot_ctl.row_end = in_eor_ff;

   tkac_slot_bank #(
      .MAX_SLOTS (MAX_SLOTS),
      .CLASS_W   (CLASS_W),
      .KW        (KW)
   ) u_slot_bank (
      .clock      (clock),
      .reset      (reset),
      .ctl        (slot_ctl),
      .logit      (in_logit_ff),
      .class_num  (class_ff),
      .label      (in_label_ff),
      .slots_used (slots_used),
      .hit        (hit)
   );

   always_comb begin
      if (in_eor_ff) begin
         class_in = '0;
      end else if (int'(class_ff) < MAX_CLASSES - 1) begin
         class_in = class_ff + CLASS_W'(1);
      end else begin
         class_in = class_ff;
      end
      if (hit && int'(correct_ff) < MAX_BATCH) begin
         correct_in = correct_ff + CORR_W'(1);
      end else begin
         correct_in = correct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_k_ff <= TOPK_RESET;
      end else if (csr_we) begin
         top_k_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_logit_ff <= req_logit;
         in_label_ff <= req_label;
         in_eor_ff   <= req_end_of_row;
         in_eob_ff   <= req_end_of_batch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff   <= '0;
         correct_ff <= '0;
      end else if (step) begin
         class_ff <= class_in;
         if (in_eor_ff) begin
            correct_ff <= in_eob_ff ? '0 : correct_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_eor_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_eor_ff) begin
         rsp_hit_ff     <= hit;
         rsp_correct_ff <= COUNT_W'(correct_in);
         rsp_done_ff    <= in_eob_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row_hit       = rsp_hit_ff;
   assign rsp_batch_correct = rsp_correct_ff;
   assign rsp_batch_done    = rsp_done_ff;

   a_row_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      step && in_eor_ff |=> rsp_valid_ff)
      else $error("row end did not load the response register");

   a_full_rsp_blocks_row_end: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_eor_ff && rsp_valid_ff && !rsp_ready |-> !step && !req_ready)
      else $error("row end advanced over a stalled response");

   a_batch_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && in_eor_ff && in_eob_ff |=> correct_ff == '0)
      else $error("correct count not cleared after batch end");

   a_correct_bound: assert property (@(posedge clock) disable iff (reset)
      int'(correct_ff) <= MAX_BATCH)
      else $error("correct count above saturation");

   a_class_bound: assert property (@(posedge clock) disable iff (reset)
      int'(class_ff) <= MAX_CLASSES - 1)
      else $error("class counter above saturation");

endmodule
